[hw/rtl/amsif_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan sequencer package
// Shared constants, register map and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package amsif_pkg;

   localparam int NUM_SLOTS_DEF      = 16;
   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int FILTER_DIVISOR_DEF = 10;

   localparam int CHAN_W    = 4;
   localparam int SLOT_W    = 4;
   localparam int SEQ_LEN_W = 5;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam logic [CSR_DATA_W-1:0] CHAN_SEQ_RESET = 64'hFEDC_BA98_7654_3210;
   localparam logic [SEQ_LEN_W-1:0]  SEQ_LEN_RESET  = 5'd16;

   localparam logic REG_CHAN_SEQ = 1'b0;
   localparam logic REG_SEQ_LEN  = 1'b1;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   localparam logic KIND_SELECT = 1'b0;
   localparam logic KIND_VALUE  = 1'b1;

   typedef struct packed {
      logic ready;
      logic capture;
      logic start;
      logic mul;
      logic update;
      logic load_select;
      logic rd_first;
      logic rd_dump;
      logic dump_load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_start;
      logic in_range;
      logic next_in_range;
      logic out_free;
      logic dump_last;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/amsif_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan sequencer channels
// Valid/ready interfaces for the request and response streams.
// ----------------------------------------------------------------------------
interface amsif_req_if #(
   parameter int SAMPLE_BITS = amsif_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface amsif_rsp_if #(
   parameter int SAMPLE_BITS = amsif_pkg::SAMPLE_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic                        out_kind;
   logic [amsif_pkg::CHAN_W-1:0] mux_channel;
   logic [amsif_pkg::SLOT_W-1:0] slot;
   logic [SAMPLE_BITS-1:0]      value;
   logic                        last;

   modport source (output valid, output out_kind, output mux_channel, output slot,
                   output value, output last, input ready);
   modport sink   (input valid, input out_kind, input mux_channel, input slot,
                   input value, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/adc_mux_sequencer_iir_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC mux sequencer with per-slot exponential averaging
// Scans a channel list and reports smoothed slot values once per frame.
// ----------------------------------------------------------------------------
// A start transaction returns the channel of slot 0 through ST_EMIT, once the
// response register is free. A conversion transaction during a scan reads the
// slot RAM, multiplies the difference by the reciprocal, writes the update
// and, if another slot of the scan follows, loads the next channel select. After the
// last slot, each conversion transaction primes the single read port of the
// slot RAM, then returns the value of every slot of the effective sequence
// length in order at one per cycle while the response stream is not stalled.
// The next transaction is taken once the controller is back in ST_IDLE. Slot
// values read as zero until first written; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module adc_mux_sequencer_iir_filter #(
   parameter int NUM_SLOTS      = amsif_pkg::NUM_SLOTS_DEF,
   parameter int SAMPLE_BITS    = amsif_pkg::SAMPLE_BITS_DEF,
   parameter int FILTER_DIVISOR = amsif_pkg::FILTER_DIVISOR_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   amsif_req_if.sink                             req_bus,
   amsif_rsp_if.source                           rsp_bus,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [amsif_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [amsif_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [amsif_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);

   logic [amsif_pkg::CSR_DATA_W-1:0] chan_seq;
   logic [amsif_pkg::SEQ_LEN_W-1:0]  seq_len;
   logic                             csr_wr;
   amsif_pkg::cmd_type               cmd;
   amsif_pkg::status_type            status;

   amsif_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .chan_seq (chan_seq),
      .seq_len  (seq_len),
      .csr_wr   (csr_wr)
   );

   amsif_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   amsif_datapath #(
      .NUM_SLOTS      (NUM_SLOTS),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .FILTER_DIVISOR (FILTER_DIVISOR)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .chan_seq (chan_seq),
      .seq_len  (seq_len),
      .csr_wr   (csr_wr),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
`default_nettype wire

[hw/rtl/amsif_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module amsif_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/amsif_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan sequencer registers
// APB register file holding the channel list and the sequence length.
// ----------------------------------------------------------------------------
module amsif_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [amsif_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [amsif_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [amsif_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                     pready,
   output logic      [amsif_pkg::CSR_DATA_W-1:0]    chan_seq,
   output logic      [amsif_pkg::SEQ_LEN_W-1:0]     seq_len,
   output logic                                     csr_wr
);

   logic [amsif_pkg::CSR_DATA_W-1:0] chan_seq_ff, chan_seq_in;
   logic [amsif_pkg::SEQ_LEN_W-1:0]  seq_len_ff, seq_len_in;
   logic                             wr;
   logic                             reg_sel;

   assign pready  = 1'b1;
   assign wr      = psel & penable & pwrite;
   assign reg_sel = paddr[3];

   always_comb begin
      chan_seq_in = chan_seq_ff;
      seq_len_in  = seq_len_ff;
      if (wr) begin
         unique case (reg_sel)
            amsif_pkg::REG_CHAN_SEQ: chan_seq_in = pwdata;
            amsif_pkg::REG_SEQ_LEN:  seq_len_in  = pwdata[amsif_pkg::SEQ_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         amsif_pkg::REG_CHAN_SEQ: prdata = chan_seq_ff;
         amsif_pkg::REG_SEQ_LEN:  prdata = amsif_pkg::CSR_DATA_W'(seq_len_ff);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_seq_ff <= amsif_pkg::CHAN_SEQ_RESET;
         seq_len_ff  <= amsif_pkg::SEQ_LEN_RESET;
      end else begin
         chan_seq_ff <= chan_seq_in;
         seq_len_ff  <= seq_len_in;
      end
   end

   assign chan_seq = chan_seq_ff;
   assign seq_len  = seq_len_ff;
   assign csr_wr   = wr;

endmodule
`default_nettype wire

[hw/rtl/amsif_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan sequencer controller
// State machine that steps the datapath through start, update and report.
// ----------------------------------------------------------------------------
module amsif_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire amsif_pkg::status_type status,
   output amsif_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_EMIT   = 6'b001000,
      ST_PRIME  = 6'b010000,
      ST_DUMP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_is_start) begin
                  cmd.start = 1'b1;
                  state_in  = ST_EMIT;
               end else if (status.in_range) begin
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_CALC: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.next_in_range ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_select = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_PRIME: begin
            cmd.rd_first = 1'b1;
            state_in     = ST_DUMP;
         end
         ST_DUMP: begin
            cmd.rd_dump = 1'b1;
            if (status.out_free) begin
               cmd.dump_load = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/amsif_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan sequencer datapath
// Slot index, smoothing arithmetic, slot value RAM and response register.
// ----------------------------------------------------------------------------
module amsif_datapath #(
   parameter int NUM_SLOTS      = amsif_pkg::NUM_SLOTS_DEF,
   parameter int SAMPLE_BITS    = amsif_pkg::SAMPLE_BITS_DEF,
   parameter int FILTER_DIVISOR = amsif_pkg::FILTER_DIVISOR_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   amsif_req_if.sink                             req_bus,
   amsif_rsp_if.source                           rsp_bus,
   input  wire logic [amsif_pkg::CSR_DATA_W-1:0] chan_seq,
   input  wire logic [amsif_pkg::SEQ_LEN_W-1:0]  seq_len,
   input  wire logic                             csr_wr,
   input  wire amsif_pkg::cmd_type               cmd,
   output amsif_pkg::status_type                 status
);

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SI_W   = $clog2(NUM_SLOTS + 1);
   localparam int SHIFT  = SAMPLE_BITS + 9;
   localparam int M_W    = SHIFT + 1;
   localparam int PROD_W = SAMPLE_BITS + M_W;
   localparam logic [M_W-1:0] RECIP =
      M_W'(((1 << SHIFT) + FILTER_DIVISOR - 1) / FILTER_DIVISOR);

   localparam int CW = amsif_pkg::CHAN_W;
   localparam int SW = amsif_pkg::SLOT_W;

   logic [SI_W-1:0]        len;
   logic [SI_W-1:0]        slot_index_ff, slot_index_in;
   logic [SI_W-1:0]        next_idx;
   logic [IDX_W-1:0]       dump_ff, dump_in;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [NUM_SLOTS-1:0]   vld_ff, vld_in;
   logic                   rd_vld_ff;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0] acc;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   neg;
   logic [SAMPLE_BITS-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] quot;
   logic [SAMPLE_BITS-1:0] new_acc;
   logic [SW-1:0]          sel_slot;
   logic [CW-1:0]          sel_chan;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_kind_ff, out_kind_in;
   logic [CW-1:0]          mux_channel_ff, mux_channel_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   last_ff, last_in;
   logic                   out_free;
   logic                   dump_last;

   always_comb begin
      if (seq_len == '0 || seq_len > amsif_pkg::SEQ_LEN_W'(NUM_SLOTS)) begin
         len = SI_W'(NUM_SLOTS);
      end else begin
         len = SI_W'(seq_len);
      end
   end

   assign next_idx  = slot_index_ff + SI_W'(1);
   assign dump_last = (SI_W'(dump_ff) + SI_W'(1)) == len;
   assign out_free  = ~rsp_valid_ff | rsp_bus.ready;

   always_comb begin
      slot_index_in = slot_index_ff;
      if (csr_wr || cmd.start) begin
         slot_index_in = '0;
      end else if (cmd.update) begin
         slot_index_in = next_idx;
      end
   end

   always_comb begin
      dump_in = dump_ff;
      if (cmd.rd_first) begin
         dump_in = '0;
      end else if (cmd.dump_load) begin
         dump_in = dump_ff + IDX_W'(1);
      end
   end

   always_comb begin
      if (cmd.rd_first) begin
         rd_addr = '0;
      end else if (cmd.rd_dump) begin
         rd_addr = cmd.dump_load ? (dump_ff + IDX_W'(1)) : dump_ff;
      end else begin
         rd_addr = IDX_W'(slot_index_ff);
      end
   end

   assign wr_addr = IDX_W'(slot_index_ff);

   always_comb begin
      vld_in = vld_ff;
      if (cmd.update) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   amsif_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wr_addr),
      .wr_data (new_acc),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sample_in = cmd.capture ? req_bus.sample : sample_ff;
   assign acc       = rd_vld_ff ? rd_data : '0;
   assign neg       = sample_ff < acc;
   assign mag       = neg ? (acc - sample_ff) : (sample_ff - acc);

   always_comb begin
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (cmd.mul) begin
         acc_in  = acc;
         neg_in  = neg;
         prod_in = PROD_W'(mag) * PROD_W'(RECIP);
      end
   end

   assign quot    = prod_ff[SHIFT +: SAMPLE_BITS];
   assign new_acc = neg_ff ? (acc_ff - quot) : (acc_ff + quot);

   assign sel_slot = SW'(slot_index_ff);
   assign sel_chan = (seq_len == '0) ? CW'(sel_slot) : chan_seq[sel_slot * CW +: CW];

   always_comb begin
      out_kind_in    = out_kind_ff;
      mux_channel_in = mux_channel_ff;
      slot_in        = slot_ff;
      value_in       = value_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      if (cmd.load_select) begin
         rsp_valid_in   = 1'b1;
         out_kind_in    = amsif_pkg::KIND_SELECT;
         mux_channel_in = sel_chan;
         slot_in        = sel_slot;
         value_in       = '0;
         last_in        = 1'b1;
      end else if (cmd.dump_load) begin
         rsp_valid_in   = 1'b1;
         out_kind_in    = amsif_pkg::KIND_VALUE;
         mux_channel_in = '0;
         slot_in        = SW'(dump_ff);
         value_in       = acc;
         last_in        = dump_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff <= '0;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_index_ff <= slot_index_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff      <= vld_ff[rd_addr];
      dump_ff        <= dump_in;
      sample_ff      <= sample_in;
      acc_ff         <= acc_in;
      neg_ff         <= neg_in;
      prod_ff        <= prod_in;
      out_kind_ff    <= out_kind_in;
      mux_channel_ff <= mux_channel_in;
      slot_ff        <= slot_in;
      value_ff       <= value_in;
      last_ff        <= last_in;
   end

   assign req_bus.ready       = cmd.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_kind    = out_kind_ff;
   assign rsp_bus.mux_channel = mux_channel_ff;
   assign rsp_bus.slot        = slot_ff;
   assign rsp_bus.value       = value_ff;
   assign rsp_bus.last        = last_ff;

   always_comb begin
      status               = '0;
      status.req_valid     = req_bus.valid;
      status.req_is_start  = req_bus.req_type == amsif_pkg::REQ_START;
      status.in_range      = slot_index_ff < len;
      status.next_in_range = next_idx < len;
      status.out_free      = out_free;
      status.dump_last     = dump_last;
   end

endmodule
`default_nettype wire
